[hw/rtl/pol_pkg.sv]
// Shared types, codes and constants for the positional ordered list unit.
package pol_pkg;

   // Field widths fixed by the item format
   localparam int OP_W     = 3;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 5;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   // Default list capacity
   localparam int LIST_DEPTH_DEF = 16;

   // Operation codes
   localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
   localparam logic [OP_W-1:0] OP_APPEND    = 3'd1;
   localparam logic [OP_W-1:0] OP_INS_AFTER = 3'd2;
   localparam logic [OP_W-1:0] OP_REMOVE    = 3'd3;
   localparam logic [OP_W-1:0] OP_SEARCH    = 3'd4;

   // Result status codes
   localparam logic [STATUS_W-1:0] STAT_DONE   = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_BADPOS = 2'd2;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_WRITE,
      ST_FINISH
   } pol_state_type;

endpackage

[hw/rtl/pol_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
module pol_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/positional_ordered_list_unit.sv]
// Top level of the positional ordered list unit: sequencer around one list RAM.
//
// Keeps an ordered list of up to LIST_DEPTH signed 32-bit values in a RAM.
// The request channel (req_valid/req_stall) carries one beat per operation:
// op, value and position. The response channel (rsp_valid/rsp_stall) returns
// exactly one beat per request with status, found, count, is_empty, is_full.
// Requests are taken while the sequencer is idle; the response register may
// still hold the previous beat when a new request is taken.
// Rejected requests, unused ops, a search of an empty list and removal of
// the last element go straight to the finish state. An insert with nothing
// to move (target index equal to the count) goes to the write state; other
// inserts, removes and searches first run the move or compare stream.
// The RAM moves one element per cycle through its single read and single
// write port; that sets the rate. The next request is taken only once the
// sequencer is back in idle, after the response is loaded.
// After reset the list is empty, with no clearing pass. While the receiver
// stalls, the response beat holds and a finished operation waits before it
// is loaded; no beat is dropped.
module positional_ordered_list_unit #(
   parameter int LIST_DEPTH = pol_pkg::LIST_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [pol_pkg::OP_W-1:0]        req_op,
   input  logic signed [pol_pkg::VALUE_W-1:0] req_value,
   input  logic [pol_pkg::POS_W-1:0]       req_position,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [pol_pkg::STATUS_W-1:0]    rsp_status,
   output logic                            rsp_found,
   output logic [pol_pkg::COUNT_W-1:0]     rsp_count,
   output logic                            rsp_is_empty,
   output logic                            rsp_is_full
);
   import pol_pkg::*;

   localparam int AW = $clog2(LIST_DEPTH);
   localparam int CW = $clog2(LIST_DEPTH + 1);
   localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;
   localparam logic [XW-1:0] DEPTH_X = XW'(LIST_DEPTH);

   // Sequencer state and control
   pol_state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] rd_left_ff, rd_left_in;
   logic          pend_ff, pend_in;
   logic          down_ff, down_in;
   logic          inc_ff, inc_in;
   logic          dec_ff, dec_in;
   // Operation payload
   logic [OP_W-1:0]     op_ff, op_in;
   logic [VALUE_W-1:0]  value_ff, value_in;
   logic [AW-1:0]       idx_ff, idx_in;
   logic [AW-1:0]       rd_addr_ff, rd_addr_in;
   logic [AW-1:0]       wr_addr_ff, wr_addr_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic                found_ff, found_in;
   // Response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic                rsp_found_ff, rsp_found_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic                rsp_is_empty_ff, rsp_is_empty_in;
   logic                rsp_is_full_ff, rsp_is_full_in;

   // Request decode
   pol_state_type       dec_state;
   logic [STATUS_W-1:0] dec_status;
   logic [AW-1:0]       dec_idx;
   logic [AW-1:0]       dec_rd_addr;
   logic [AW-1:0]       dec_wr_addr;
   logic [CW-1:0]       dec_moves;
   logic                dec_down;
   logic                dec_inc;
   logic                dec_dec;
   logic [XW-1:0]       cnt_x;
   logic [XW-1:0]       pos_x;
   logic [XW-1:0]       after_x;
   logic [XW-1:0]       ins_x;
   logic                full;

   // RAM ports
   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   logic [VALUE_W-1:0] mem_wdata;
   logic [VALUE_W-1:0] mem_rdata;

   logic accept;
   logic rd_issue;
   logic rsp_free;
   logic run_done;
   logic is_insert_op;
   logic [CW-1:0] count_next;
   logic [XW-1:0] count_next_x;

   assign accept   = req_valid && !req_stall;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign rd_issue = (state_ff == ST_RUN) && (rd_left_ff != '0);
   assign run_done = (rd_left_ff == '0) && !pend_ff;
   assign is_insert_op = (op_ff == OP_INS_FRONT) || (op_ff == OP_APPEND) ||
                         (op_ff == OP_INS_AFTER);

   pol_ram #(
      .WIDTH(VALUE_W),
      .DEPTH(LIST_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (rd_addr_ff),
      .rd_data (mem_rdata)
   );

   // Decode the offered request against the current count
   always_comb begin
      cnt_x       = XW'(count_ff);
      pos_x       = XW'(req_position);
      after_x     = (req_position == '0) ? XW'(1) : pos_x;
      ins_x       = (after_x < cnt_x) ? after_x : cnt_x;
      full        = (cnt_x == DEPTH_X);
      dec_state   = ST_FINISH;
      dec_status  = STAT_DONE;
      dec_idx     = '0;
      dec_rd_addr = '0;
      dec_wr_addr = '0;
      dec_moves   = '0;
      dec_down    = 1'b0;
      dec_inc     = 1'b0;
      dec_dec     = 1'b0;
      unique case (req_op) inside
         OP_INS_FRONT, OP_APPEND, OP_INS_AFTER: begin
            if (full) begin
               dec_status = STAT_FULL;
            end else if ((req_op == OP_INS_AFTER) && (after_x > cnt_x + XW'(1))) begin
               dec_status = STAT_BADPOS;
            end else begin
               if (req_op == OP_APPEND) begin
                  dec_idx = AW'(count_ff);
               end else if (req_op == OP_INS_AFTER) begin
                  dec_idx = AW'(ins_x);
               end else begin
                  dec_idx = '0;
               end
               dec_moves   = CW'(cnt_x - XW'(dec_idx));
               dec_rd_addr = AW'(cnt_x - XW'(1));
               dec_wr_addr = AW'(count_ff);
               dec_down    = 1'b1;
               dec_inc     = 1'b1;
               dec_state   = (dec_moves != '0) ? ST_RUN : ST_WRITE;
            end
         end
         OP_REMOVE: begin
            if ((req_position == '0) || (pos_x > cnt_x)) begin
               dec_status = STAT_BADPOS;
            end else begin
               dec_idx     = AW'(pos_x - XW'(1));
               dec_moves   = CW'(cnt_x - pos_x);
               dec_rd_addr = AW'(pos_x);
               dec_wr_addr = AW'(pos_x - XW'(1));
               dec_dec     = 1'b1;
               dec_state   = (dec_moves != '0) ? ST_RUN : ST_FINISH;
            end
         end
         OP_SEARCH: begin
            dec_moves = count_ff;
            dec_state = (count_ff != '0) ? ST_RUN : ST_FINISH;
         end
         default: begin
            dec_state = ST_FINISH;
         end
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = dec_state;
            end
         end
         ST_RUN: begin
            if (run_done) begin
               state_in = is_insert_op ? ST_WRITE : ST_FINISH;
            end
         end
         ST_WRITE: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State outputs: request stall and RAM write port
   always_comb begin
      req_stall = 1'b1;
      mem_we    = 1'b0;
      mem_waddr = wr_addr_ff;
      mem_wdata = mem_rdata;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
         end
         ST_RUN: begin
            mem_we = pend_ff && (op_ff != OP_SEARCH);
         end
         ST_WRITE: begin
            mem_we    = 1'b1;
            mem_waddr = idx_ff;
            mem_wdata = value_ff;
         end
         ST_FINISH: begin
            mem_we = 1'b0;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   // Count after the held operation
   always_comb begin
      count_next = count_ff;
      if (status_ff == STAT_DONE) begin
         if (inc_ff) begin
            count_next = count_ff + CW'(1);
         end else if (dec_ff) begin
            count_next = count_ff - CW'(1);
         end
      end
      count_next_x = XW'(count_next);
   end

   // Datapath: latch request, step the move stream, load the response
   always_comb begin
      op_in      = op_ff;
      value_in   = value_ff;
      idx_in     = idx_ff;
      rd_addr_in = rd_addr_ff;
      wr_addr_in = wr_addr_ff;
      rd_left_in = rd_left_ff;
      down_in    = down_ff;
      inc_in     = inc_ff;
      dec_in     = dec_ff;
      status_in  = status_ff;
      found_in   = found_ff;
      pend_in    = rd_issue;
      count_in   = count_ff;

      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_status_in   = rsp_status_ff;
      rsp_found_in    = rsp_found_ff;
      rsp_count_in    = rsp_count_ff;
      rsp_is_empty_in = rsp_is_empty_ff;
      rsp_is_full_in  = rsp_is_full_ff;

      if (accept) begin
         op_in      = req_op;
         value_in   = req_value;
         idx_in     = dec_idx;
         rd_addr_in = dec_rd_addr;
         wr_addr_in = dec_wr_addr;
         rd_left_in = dec_moves;
         down_in    = dec_down;
         inc_in     = dec_inc;
         dec_in     = dec_dec;
         status_in  = dec_status;
         found_in   = 1'b0;
      end

      // advance read pointer
      if (rd_issue) begin
         rd_addr_in = down_ff ? rd_addr_ff - AW'(1) : rd_addr_ff + AW'(1);
         rd_left_in = rd_left_ff - CW'(1);
      end

      // consume read data: move it or compare it
      if ((state_ff == ST_RUN) && pend_ff) begin
         wr_addr_in = down_ff ? wr_addr_ff - AW'(1) : wr_addr_ff + AW'(1);
         if ((op_ff == OP_SEARCH) && (mem_rdata == value_ff)) begin
            found_in = 1'b1;
         end
      end

      // hand off the result
      if ((state_ff == ST_FINISH) && rsp_free) begin
         count_in        = count_next;
         rsp_valid_in    = 1'b1;
         rsp_status_in   = status_ff;
         rsp_found_in    = found_ff;
         rsp_count_in    = count_next_x[COUNT_W-1:0];
         rsp_is_empty_in = (count_next == '0);
         rsp_is_full_in  = (count_next_x == DEPTH_X);
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rd_left_ff   <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_left_ff   <= rd_left_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff           <= op_in;
      value_ff        <= value_in;
      idx_ff          <= idx_in;
      rd_addr_ff      <= rd_addr_in;
      wr_addr_ff      <= wr_addr_in;
      down_ff         <= down_in;
      inc_ff          <= inc_in;
      dec_ff          <= dec_in;
      status_ff       <= status_in;
      found_ff        <= found_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_found_ff    <= rsp_found_in;
      rsp_count_ff    <= rsp_count_in;
      rsp_is_empty_ff <= rsp_is_empty_in;
      rsp_is_full_ff  <= rsp_is_full_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_count    = rsp_count_ff;
   assign rsp_is_empty = rsp_is_empty_ff;
   assign rsp_is_full  = rsp_is_full_ff;

endmodule

[hw/rtl/pol_chk.sv]
// Port-level checker for the positional ordered list unit, with its bind.
module pol_chk #(
   parameter int LIST_DEPTH = pol_pkg::LIST_DEPTH_DEF
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [pol_pkg::STATUS_W-1:0] rsp_status,
   input logic                         rsp_found,
   input logic [pol_pkg::COUNT_W-1:0]  rsp_count,
   input logic                         rsp_is_empty,
   input logic                         rsp_is_full
);
   import pol_pkg::*;

   // A stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_found) && $stable(rsp_count))
      else $error("response beat changed while stalled");

   // Empty flag agrees with the count
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_empty == (rsp_count == '0)))
      else $error("empty flag disagrees with count");

   // Full flag agrees with the count
   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_full == (int'(rsp_count) == LIST_DEPTH)))
      else $error("full flag disagrees with count");

   // Full rejection only with a full list
   a_full_rej: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STAT_FULL) |-> rsp_is_full)
      else $error("full rejection while not full");

   // A hit comes only from a completed operation on a non-empty list
   a_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> (rsp_status == STAT_DONE) && !rsp_is_empty)
      else $error("found flag on rejected or empty result");

endmodule

bind positional_ordered_list_unit pol_chk #(
   .LIST_DEPTH(LIST_DEPTH)
) u_pol_chk (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_status   (rsp_status),
   .rsp_found    (rsp_found),
   .rsp_count    (rsp_count),
   .rsp_is_empty (rsp_is_empty),
   .rsp_is_full  (rsp_is_full)
);
